/* design/lgge_pkg.sv */
// Shared types, codes and defaults for the life grid generation engine.
`timescale 1ns / 1ps

package lgge_pkg;

   // Default grid geometry
   localparam int GRID_ROWS_DEF = 32;
   localparam int GRID_COLS_DEF = 128;

   // Fixed field and register widths
   localparam int KIND_W     = 2;
   localparam int ROW_W      = 5;
   localparam int COL_W      = 7;
   localparam int ROWS_REG_W = 6;
   localparam int COLS_REG_W = 8;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int COUNT_W    = 4;

   // Request kinds
   localparam logic [KIND_W-1:0] KIND_WRITE   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_ADVANCE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_READ    = 2'd2;

   // Register indexes (paddr bit 2 selects the register)
   localparam logic REG_ACTIVE_ROWS = 1'b0;
   localparam logic REG_ACTIVE_COLS = 1'b1;

   // Register reset values
   localparam logic [ROWS_REG_W-1:0] ACTIVE_ROWS_RST = 6'd32;
   localparam logic [COLS_REG_W-1:0] ACTIVE_COLS_RST = 8'd128;

   // B3/S23 rule counts
   localparam logic [COUNT_W-1:0] BIRTH_COUNT  = 4'd3;
   localparam logic [COUNT_W-1:0] SURVIVE_LOW  = 4'd2;
   localparam logic [COUNT_W-1:0] SURVIVE_HIGH = 4'd3;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [ROW_W-1:0]  row;
      logic [COL_W-1:0]  col;
      logic              cell_in;
   } lgge_req_type;

   typedef struct packed {
      logic cell_out;
      logic stable;
      logic out_of_range;
   } lgge_rsp_type;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } lgge_state_type;

   typedef struct packed {
      logic accept;
      logic shift;
      logic last_step;
   } lgge_ctrl_type;

endpackage

/* design/lgge_row_cell.sv */
// One cell of the row chain: holds one grid row and takes its neighbor's row on shift.
`timescale 1ns / 1ps

module lgge_row_cell
   import lgge_pkg::*;
#(
   parameter int GRID_COLS = GRID_COLS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 shift,
   input  logic [GRID_COLS-1:0] row_d,
   output logic [GRID_COLS-1:0] row_q
);

   logic [GRID_COLS-1:0] row_ff;
   logic [GRID_COLS-1:0] row_in;

   // Load the neighbor's row while the chain rotates
   always_comb begin
      row_in = shift ? row_d : row_ff;
   end

   // Grid clears to dead at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
      end else begin
         row_ff <= row_in;
      end
   end

   assign row_q = row_ff;

endmodule

/* design/lgge_rule_row.sv */
// B3/S23 update of one full row from the rows above, at and below it.
`timescale 1ns / 1ps

module lgge_rule_row
   import lgge_pkg::*;
#(
   parameter int GRID_COLS = GRID_COLS_DEF
) (
   input  logic [GRID_COLS-1:0] up_row,
   input  logic [GRID_COLS-1:0] mid_row,
   input  logic [GRID_COLS-1:0] dn_row,
   input  logic [GRID_COLS-1:0] col_mask,
   output logic [GRID_COLS-1:0] new_row,
   output logic                 changed
);

   logic [GRID_COLS+1:0] up_p;
   logic [GRID_COLS+1:0] mid_p;
   logic [GRID_COLS+1:0] dn_p;

   // Pad with dead cells at both edges; inactive columns count as dead
   assign up_p  = {1'b0, up_row  & col_mask, 1'b0};
   assign mid_p = {1'b0, mid_row & col_mask, 1'b0};
   assign dn_p  = {1'b0, dn_row  & col_mask, 1'b0};

   // One neighbor counter per column
   for (genvar c = 0; c < GRID_COLS; c++) begin : g_col
      logic [COUNT_W-1:0] cnt;
      logic               alive;
      logic               next_bit;

      always_comb begin
         cnt = COUNT_W'(up_p[c])  + COUNT_W'(up_p[c+1]) + COUNT_W'(up_p[c+2])
             + COUNT_W'(mid_p[c])                        + COUNT_W'(mid_p[c+2])
             + COUNT_W'(dn_p[c])  + COUNT_W'(dn_p[c+1]) + COUNT_W'(dn_p[c+2]);
         alive = mid_row[c];
         if (alive) begin
            next_bit = (cnt == SURVIVE_LOW) || (cnt == SURVIVE_HIGH);
         end else begin
            next_bit = (cnt == BIRTH_COUNT);
         end
      end

      // Columns outside the active area keep their value
      assign new_row[c] = col_mask[c] ? next_bit : mid_row[c];
   end

   assign changed = |((new_row ^ mid_row) & col_mask);

endmodule

/* design/lgge_ctrl.sv */
// Sequencer: runs one full rotation of the row chain per request.
`timescale 1ns / 1ps

module lgge_ctrl
   import lgge_pkg::*;
#(
   parameter  int GRID_ROWS = GRID_ROWS_DEF,
   localparam int STEP_W    = $clog2(GRID_ROWS)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   output lgge_ctrl_type     ctrl,
   output logic [STEP_W-1:0] step
);

   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(GRID_ROWS - 1);

   lgge_state_type    state_ff;
   lgge_state_type    state_in;
   logic [STEP_W-1:0] step_ff;
   logic [STEP_W-1:0] step_in;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (step_ff == LAST_STEP) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs
   always_comb begin
      ctrl = '0;
      busy = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            ctrl.accept = start;
         end
         ST_RUN: begin
            busy           = 1'b1;
            ctrl.shift     = 1'b1;
            ctrl.last_step = (step_ff == LAST_STEP);
         end
         default: begin
            ctrl = '0;
         end
      endcase
   end

   // Row step counter: which row sits at the head of the chain
   always_comb begin
      step_in = step_ff;
      if (ctrl.accept) begin
         step_in = '0;
      end else if (ctrl.shift && !ctrl.last_step) begin
         step_in = step_ff + STEP_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   assign step = step_ff;

endmodule

/* design/life_grid_generation_engine_top.sv */
// Top level of the life grid generation engine: row chain, rule unit, control, registers.
// The grid sits in a chain of GRID_ROWS row cells that rotates by one row per cycle while busy.
// Every request (write cell, read cell, advance one B3/S23 generation) makes one full
// rotation: busy stays high while the chain rotates after start is taken, the result
// appears on rsp_data with a one-cycle rsp_valid strobe right after busy drops, and
// the next start can be taken in that same cycle. An advance updates a whole row per
// cycle at the head of the chain. The result strobe cannot be held off, so the
// receiver must take it in that cycle. Registers: active_rows at 0x0, active_cols
// at 0x4; write them only while busy is low and no result is pending.
`timescale 1ns / 1ps

module life_grid_generation_engine_top
   import lgge_pkg::*;
#(
   parameter int GRID_ROWS = GRID_ROWS_DEF,
   parameter int GRID_COLS = GRID_COLS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  start,
   output logic                  busy,
   input  lgge_req_type          req_data,
   // result channel
   output logic                  rsp_valid,
   output lgge_rsp_type          rsp_data,
   // register port
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam int STEP_W = $clog2(GRID_ROWS);
   localparam int CIDX_W = $clog2(GRID_COLS);

   lgge_ctrl_type            ctrl;
   logic [STEP_W-1:0]        step;

   logic [ROWS_REG_W-1:0]    active_rows_ff;
   logic [ROWS_REG_W-1:0]    active_rows_in;
   logic [COLS_REG_W-1:0]    active_cols_ff;
   logic [COLS_REG_W-1:0]    active_cols_in;
   logic                     csr_write;
   logic [ROWS_REG_W-1:0]    num_rows;
   logic [COLS_REG_W-1:0]    num_cols;
   logic [GRID_COLS-1:0]     col_mask;

   lgge_req_type             req_ff;
   lgge_req_type             req_in;
   logic [GRID_COLS-1:0]     prev_ff;
   logic [GRID_COLS-1:0]     prev_in;
   logic                     same_ff;
   logic                     same_in;
   logic                     cap_ff;
   logic                     cap_in;
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   lgge_rsp_type             rsp_ff;
   lgge_rsp_type             rsp_in;

   logic [GRID_COLS-1:0]     row_q [GRID_ROWS];
   logic [GRID_COLS-1:0]     head_row;
   logic [GRID_COLS-1:0]     head_new;
   logic [GRID_COLS-1:0]     up_row;
   logic [GRID_COLS-1:0]     dn_row;
   logic [GRID_COLS-1:0]     rule_row;
   logic [GRID_COLS-1:0]     wr_row;
   logic                     rule_changed;
   logic [CIDX_W-1:0]        col_idx;
   logic                     in_area;
   logic                     row_hit;
   logic                     row_act;
   logic                     dn_act;
   logic                     is_write;
   logic                     is_read;
   logic                     is_adv;

   // Sequencer
   lgge_ctrl #(
      .GRID_ROWS (GRID_ROWS)
   ) u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .ctrl  (ctrl),
      .step  (step)
   );

   // Configuration registers
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      active_rows_in = active_rows_ff;
      active_cols_in = active_cols_ff;
      if (csr_write) begin
         case (paddr[2])
            REG_ACTIVE_ROWS: active_rows_in = pwdata[ROWS_REG_W-1:0];
            REG_ACTIVE_COLS: active_cols_in = pwdata[COLS_REG_W-1:0];
            default: begin
               active_rows_in = active_rows_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_rows_ff <= ACTIVE_ROWS_RST;
         active_cols_ff <= ACTIVE_COLS_RST;
      end else begin
         active_rows_ff <= active_rows_in;
         active_cols_ff <= active_cols_in;
      end
   end

   always_comb begin
      case (paddr[2])
         REG_ACTIVE_ROWS: prdata = CSR_DATA_W'(active_rows_ff);
         REG_ACTIVE_COLS: prdata = CSR_DATA_W'(active_cols_ff);
         default:         prdata = '0;
      endcase
   end

   assign pready = 1'b1;

   // Effective active area: zero counts as one, oversize clamps to the grid
   always_comb begin
      if (active_rows_ff == '0) begin
         num_rows = ROWS_REG_W'(1);
      end else if (32'(active_rows_ff) > 32'(GRID_ROWS)) begin
         num_rows = ROWS_REG_W'(GRID_ROWS);
      end else begin
         num_rows = active_rows_ff;
      end
      if (active_cols_ff == '0) begin
         num_cols = COLS_REG_W'(1);
      end else if (32'(active_cols_ff) > 32'(GRID_COLS)) begin
         num_cols = COLS_REG_W'(GRID_COLS);
      end else begin
         num_cols = active_cols_ff;
      end
   end

   for (genvar c = 0; c < GRID_COLS; c++) begin : g_mask
      assign col_mask[c] = (32'(c) < 32'(num_cols));
   end

   // Row chain: cell k takes cell k+1, the last cell takes the updated head row
   for (genvar k = 0; k < GRID_ROWS; k++) begin : g_cell
      logic [GRID_COLS-1:0] cell_d;
      if (k == GRID_ROWS - 1) begin : g_tail
         assign cell_d = head_new;
      end else begin : g_body
         assign cell_d = row_q[k+1];
      end
      lgge_row_cell #(
         .GRID_COLS (GRID_COLS)
      ) u_cell (
         .clock (clock),
         .reset (reset),
         .shift (ctrl.shift),
         .row_d (cell_d),
         .row_q (row_q[k])
      );
   end

   assign head_row = row_q[0];

   // Request decode against the latched request
   assign is_write = (req_ff.kind == KIND_WRITE);
   assign is_adv   = (req_ff.kind == KIND_ADVANCE);
   assign is_read  = (req_ff.kind == KIND_READ);
   assign col_idx  = CIDX_W'(req_ff.col);
   assign in_area  = (32'(req_ff.row) < 32'(num_rows)) && (32'(req_ff.col) < 32'(num_cols));
   assign row_hit  = (32'(step) == 32'(req_ff.row));
   assign row_act  = (32'(step) < 32'(num_rows));
   assign dn_act   = ((32'(step) + 32'd1) < 32'(num_rows));

   // Neighbor rows: the old row above is kept aside, the row below is cell 1
   assign up_row = (step == '0) ? '0 : prev_ff;
   assign dn_row = dn_act ? row_q[1] : '0;

   lgge_rule_row #(
      .GRID_COLS (GRID_COLS)
   ) u_rule (
      .up_row   (up_row),
      .mid_row  (head_row),
      .dn_row   (dn_row),
      .col_mask (col_mask),
      .new_row  (rule_row),
      .changed  (rule_changed)
   );

   // Head row as it re-enters the chain
   always_comb begin
      wr_row          = head_row;
      wr_row[col_idx] = req_ff.cell_in;
      head_new        = head_row;
      case (req_ff.kind)
         KIND_WRITE: begin
            if (row_hit && in_area) begin
               head_new = wr_row;
            end
         end
         KIND_ADVANCE: begin
            if (row_act) begin
               head_new = rule_row;
            end
         end
         default: begin
            head_new = head_row;
         end
      endcase
   end

   // Per-request working state
   always_comb begin
      req_in  = req_ff;
      prev_in = prev_ff;
      same_in = same_ff;
      cap_in  = cap_ff;
      if (ctrl.accept) begin
         req_in  = req_data;
         same_in = 1'b1;
         cap_in  = 1'b0;
      end else if (ctrl.shift) begin
         prev_in = head_row;
         if (is_adv && row_act && rule_changed) begin
            same_in = 1'b0;
         end
         if (is_read && row_hit && in_area) begin
            cap_in = head_row[col_idx];
         end
      end
   end

   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      prev_ff <= prev_in;
      same_ff <= same_in;
      cap_ff  <= cap_in;
   end

   // Result register, loaded on the last step of the rotation
   always_comb begin
      rsp_valid_in        = ctrl.shift && ctrl.last_step;
      rsp_in              = rsp_ff;
      if (rsp_valid_in) begin
         rsp_in.cell_out     = cap_in;
         rsp_in.stable       = is_adv && same_in;
         rsp_in.out_of_range = (is_write || is_read) && !in_area;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* design/lgge_checker.sv */
// Port-level checks for the life grid generation engine, bound to the top level.
`timescale 1ns / 1ps

module lgge_checker
   import lgge_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         start,
   input logic         busy,
   input logic         rsp_valid,
   input lgge_rsp_type rsp_data
);

   // A taken request keeps the engine busy in the next cycle
   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after request taken");

   // A result comes exactly when busy drops
   a_rsp_on_busy_fall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $fell(busy))
      else $error("result strobe without end of rotation");

   // Results are single-cycle strobes
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held two cycles");

   // A stable flag only comes from an advance, which has no read bit or range flag
   a_stable_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.stable) |-> (!rsp_data.cell_out && !rsp_data.out_of_range))
      else $error("stable result mixed with cell access flags");

endmodule

bind life_grid_generation_engine_top lgge_checker u_lgge_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
